// ----- rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Fixed Q8.8 widths, command codes and the beat that walks the divider row.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int unsigned Width    = 16;
  localparam int unsigned FracBits = 8;
  localparam int unsigned ProdW    = 2 * Width + 1;            // 33: sum of two products
  localparam int unsigned NumW     = ProdW + FracBits;         // 41: shifted numerator
  localparam int unsigned DenW     = 2 * Width + 1;            // 33: squared magnitude
  localparam int unsigned NumCells = NumW;                     // one quotient bit per cell

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  // Beat travelling down the row of cells.
  typedef struct packed {
    logic                   vld;
    logic                   is_div;
    logic                   dz;
    logic                   re_neg;
    logic                   im_neg;
    logic [NumW-1:0]        re_num;   // remaining numerator bits (shift out top)
    logic [NumW-1:0]        im_num;
    logic [DenW:0]          re_rem;
    logic [DenW:0]          im_rem;
    logic [NumW-1:0]        re_quo;
    logic [NumW-1:0]        im_quo;
    logic [DenW-1:0]        den;
  } beat_t;

endpackage

// ----- rtl/cau_if.sv -----
// ----------------------------------------------------------------------------
// cau_in_if / cau_out_if: valid/ready channels of the complex arithmetic unit
// Operand channel and result channel with source and sink modports.
// ----------------------------------------------------------------------------
interface cau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [cau_pkg::Width-1:0] a_real;
  logic signed [cau_pkg::Width-1:0] a_imag;
  logic signed [cau_pkg::Width-1:0] b_real;
  logic signed [cau_pkg::Width-1:0] b_imag;
  modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic        valid;
  logic        ready;
  logic signed [cau_pkg::Width-1:0] res_real;
  logic signed [cau_pkg::Width-1:0] res_imag;
  logic        saturated;
  logic        divide_by_zero;
  modport source (output valid, res_real, res_imag, saturated, divide_by_zero, input ready);
  modport sink   (input valid, res_real, res_imag, saturated, divide_by_zero, output ready);
endinterface

// ----- rtl/complex_arithmetic_unit.sv -----
// Every command, division or not, takes the same path from operand beat to result beat.
// Throughput: one beat per cycle; the row of 41 divider cells yields one quotient bit each.
// The whole pipeline holds while the result register is full and not taken.
// Reset: asynchronous, active low; clears all valid bits, no result pending.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: Q8.8 complex add, subtract, multiply and divide
// Product front end, a row of restoring-division cells, saturating back end.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  cau_in_if.sink   in_i,
  cau_out_if.source out_o
);

  localparam int unsigned N = cau_pkg::NumCells;

  logic           en;
  cau_pkg::beat_t row [N+1];

  // advance unless the result register holds an untaken beat
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  cau_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (in_i.valid),
    .command_i (in_i.command),
    .a_real_i  (in_i.a_real),
    .a_imag_i  (in_i.a_imag),
    .b_real_i  (in_i.b_real),
    .b_imag_i  (in_i.b_imag),
    .beat_o    (row[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    cau_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (row[g]),
      .beat_o (row[g+1])
    );
  end

  cau_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .beat_i     (row[N]),
    .vld_o      (out_o.valid),
    .res_real_o (out_o.res_real),
    .res_imag_o (out_o.res_imag),
    .sat_o      (out_o.saturated),
    .dz_o       (out_o.divide_by_zero)
  );

endmodule

// ----- rtl/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front: operand products and numerator set-up
// Two registered stages: products, squares and add/subtract sums, then the combined numerators and divisor.
// Add, subtract and multiply results are carried in the quotient field with no
// division; the row of cells then passes them through unchanged.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [1:0]            command_i,
  input  logic signed [cau_pkg::Width-1:0] a_real_i,
  input  logic signed [cau_pkg::Width-1:0] a_imag_i,
  input  logic signed [cau_pkg::Width-1:0] b_real_i,
  input  logic signed [cau_pkg::Width-1:0] b_imag_i,
  output cau_pkg::beat_t        beat_o
);

  localparam int unsigned W  = cau_pkg::Width;
  localparam int unsigned PW = cau_pkg::ProdW;
  localparam int unsigned NW = cau_pkg::NumW;
  localparam int unsigned DW = cau_pkg::DenW;
  localparam int unsigned F  = cau_pkg::FracBits;

  // stage 1 registers
  logic                     vld_q;
  logic [1:0]               cmd_q;
  logic signed [2*W-1:0]    p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [W:0]        s_re_q, s_im_q;
  logic [2*W-1:0]           m_r_q, m_i_q;
  cau_pkg::beat_t           beat_d, beat_q;

  // multiply plan: ar*br, ai*bi, ar*bi, ai*br; divide plan reuses the same four
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q  <= command_i;
      p_rr_q <= a_real_i * b_real_i;
      p_ii_q <= a_imag_i * b_imag_i;
      p_ri_q <= a_real_i * b_imag_i;
      p_ir_q <= a_imag_i * b_real_i;
      m_r_q  <= b_real_i * b_real_i;
      m_i_q  <= b_imag_i * b_imag_i;
      if (command_i == cau_pkg::CmdSub) begin
        s_re_q <= {a_real_i[W-1], a_real_i} - {b_real_i[W-1], b_real_i};
        s_im_q <= {a_imag_i[W-1], a_imag_i} - {b_imag_i[W-1], b_imag_i};
      end else begin
        s_re_q <= {a_real_i[W-1], a_real_i} + {b_real_i[W-1], b_real_i};
        s_im_q <= {a_imag_i[W-1], a_imag_i} + {b_imag_i[W-1], b_imag_i};
      end
    end
  end

  logic signed [PW-1:0] v_re, v_im, f_re, f_im;
  logic [PW-1:0]        a_re, a_im;
  logic [DW-1:0]        den;

  always_comb begin
    beat_d     = '0;
    beat_d.vld = vld_q;
    den        = {1'b0, m_r_q} + {1'b0, m_i_q};
    v_re       = '0;
    v_im       = '0;
    case (cmd_q)
      cau_pkg::CmdAdd, cau_pkg::CmdSub: begin
        v_re = PW'(s_re_q);
        v_im = PW'(s_im_q);
      end
      cau_pkg::CmdMul: begin
        f_re = PW'(p_rr_q) - PW'(p_ii_q);
        f_im = PW'(p_ri_q) + PW'(p_ir_q);
        v_re = f_re >>> F;
        v_im = f_im >>> F;
      end
      default: begin
        v_re = PW'(p_rr_q) + PW'(p_ii_q);
        v_im = PW'(p_ir_q) - PW'(p_ri_q);
      end
    endcase
    f_re = '0;
    f_im = '0;
    a_re = v_re[PW-1] ? PW'(-v_re) : PW'(v_re);
    a_im = v_im[PW-1] ? PW'(-v_im) : PW'(v_im);
    beat_d.re_neg = v_re[PW-1];
    beat_d.im_neg = v_im[PW-1];
    beat_d.den    = den;
    if (cmd_q == cau_pkg::CmdDiv) begin
      beat_d.is_div = (den != '0);
      beat_d.dz     = (den == '0);
      beat_d.re_num = {a_re, {F{1'b0}}};
      beat_d.im_num = {a_im, {F{1'b0}}};
    end else begin
      // result rides in the quotient field untouched
      beat_d.re_quo = NW'(a_re);
      beat_d.im_quo = NW'(a_im);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q.vld <= 1'b0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

// ----- rtl/cau_cell.sv -----
// ----------------------------------------------------------------------------
// cau_cell: one restoring-division step of the divider row
// Takes one numerator bit into both remainders and emits one quotient bit per part.
// ----------------------------------------------------------------------------
module cau_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  cau_pkg::beat_t beat_i,
  output cau_pkg::beat_t beat_o
);

  localparam int unsigned NW = cau_pkg::NumW;
  localparam int unsigned DW = cau_pkg::DenW;

  cau_pkg::beat_t beat_d, beat_q;
  logic [DW:0]    sh_re, sh_im;
  logic [DW+1:0]  df_re, df_im;

  always_comb begin
    beat_d = beat_i;
    sh_re  = {beat_i.re_rem[DW-1:0], beat_i.re_num[NW-1]};
    sh_im  = {beat_i.im_rem[DW-1:0], beat_i.im_num[NW-1]};
    df_re  = {1'b0, sh_re} - {2'b0, beat_i.den};
    df_im  = {1'b0, sh_im} - {2'b0, beat_i.den};
    if (beat_i.is_div) begin
      beat_d.re_num = {beat_i.re_num[NW-2:0], 1'b0};
      beat_d.im_num = {beat_i.im_num[NW-2:0], 1'b0};
      beat_d.re_rem = df_re[DW+1] ? sh_re : df_re[DW:0];
      beat_d.im_rem = df_im[DW+1] ? sh_im : df_im[DW:0];
      beat_d.re_quo = {beat_i.re_quo[NW-2:0], ~df_re[DW+1]};
      beat_d.im_quo = {beat_i.im_quo[NW-2:0], ~df_im[DW+1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q.vld <= 1'b0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

// ----- rtl/cau_back.sv -----
// ----------------------------------------------------------------------------
// cau_back: sign restore, saturation and output register
// Clamps both parts to the Q8.8 range and holds the result beat.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  cau_pkg::beat_t beat_i,
  output logic           vld_o,
  output logic signed [cau_pkg::Width-1:0] res_real_o,
  output logic signed [cau_pkg::Width-1:0] res_imag_o,
  output logic           sat_o,
  output logic           dz_o
);

  localparam int unsigned W  = cau_pkg::Width;
  localparam int unsigned NW = cau_pkg::NumW;

  logic [W-1:0] re_d, im_d;
  logic         sre, sim;
  logic         vld_q, sat_q, dz_q;
  logic [W-1:0] re_q, im_q;

  function automatic logic [W:0] clamp(input logic neg, input logic [NW-1:0] mag);
    logic [W:0] r;
    if (neg) begin
      if (mag > NW'({1'b1, {(W-1){1'b0}}})) begin
        r = {1'b1, 1'b1, {(W-1){1'b0}}};
      end else begin
        r = {1'b0, W'(~mag[W-1:0] + 1'b1)};
      end
    end else begin
      if (mag > NW'({1'b0, {(W-1){1'b1}}})) begin
        r = {1'b1, 1'b0, {(W-1){1'b1}}};
      end else begin
        r = {1'b0, mag[W-1:0]};
      end
    end
    return r;
  endfunction

  always_comb begin
    {sre, re_d} = clamp(beat_i.re_neg, beat_i.re_quo);
    {sim, im_d} = clamp(beat_i.im_neg, beat_i.im_quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q  <= re_d;
      im_q  <= im_d;
      sat_q <= sre | sim;
      dz_q  <= beat_i.dz;
    end
  end

  assign vld_o      = vld_q;
  assign res_real_o = re_q;
  assign res_imag_o = im_q;
  assign sat_o      = sat_q;
  assign dz_o       = dz_q;

endmodule

// ----- rtl/cau_checker.sv -----
// ----------------------------------------------------------------------------
// cau_checker: port-level checks of the complex arithmetic unit
// Watches both channels and flags results that break the unit's rules.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [cau_pkg::Width-1:0] res_real,
  input logic signed [cau_pkg::Width-1:0] res_imag,
  input logic saturated,
  input logic divide_by_zero
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(res_real) && $stable(res_imag))
    else $error("result beat changed while stalled");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && divide_by_zero |-> res_real == '0 && res_imag == '0 && !saturated)
    else $error("zero divisor result not cleared");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .res_real       (out_o.res_real),
  .res_imag       (out_o.res_imag),
  .saturated      (out_o.saturated),
  .divide_by_zero (out_o.divide_by_zero)
);

// ----- verif/complex_arithmetic_unit_test.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_test: self-checking bench of the complex arithmetic unit
// Directed table of operand beats, then random beats, all checked in order
// against a fixed-point predictor; random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module complex_arithmetic_unit_test;

  typedef struct {
    logic [1:0]         command;
    logic signed [15:0] ar, ai, br, bi;
  } operands_t;

  typedef struct {
    logic signed [15:0] re, im;
    logic               sat, dz;
  } answer_t;

  typedef struct {
    operands_t op;
    logic      known;   // expected answer typed into the row
    answer_t   ans;
  } row_t;

  localparam longint Bound = 64'sd1 << 48;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  cau_in_if  in_ch ();
  cau_out_if out_ch ();

  complex_arithmetic_unit i_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  always #1 clk_i = ~clk_i;

  answer_t answer_q[$];
  int      n_mismatch = 0;
  row_t    rows[$];

  function automatic logic signed [15:0] clamp16(longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // truncate toward zero, magnitude capped as the quotient loop caps it
  function automatic longint quotient(longint num, longint den);
    longint m, q, r;
    int i;
    m = num < 0 ? -num : num;
    q = m / den;
    r = m % den;
    for (i = 0; i < cau_pkg::FracBits; i++) begin
      if (q >= Bound) break;
      q = q << 1;
      if (r >= den - r) begin
        r = r - (den - r);
        q = q | 1;
      end else begin
        r = r + r;
      end
    end
    if (q > Bound) q = Bound;
    return num < 0 ? -q : q;
  endfunction

  function automatic answer_t predict_answer(operands_t op);
    answer_t a;
    longint ar, ai, br, bi, re, im, den;
    ar = op.ar; ai = op.ai; br = op.br; bi = op.bi;
    a.sat = 1'b0;
    a.dz = 1'b0;
    case (cau_pkg::cmd_e'(op.command))
      cau_pkg::CmdAdd: begin re = ar + br; im = ai + bi; end
      cau_pkg::CmdSub: begin re = ar - br; im = ai - bi; end
      cau_pkg::CmdMul: begin
        re = (ar * br - ai * bi) >>> cau_pkg::FracBits;
        im = (ar * bi + ai * br) >>> cau_pkg::FracBits;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          a.dz = 1'b1;
          re = 0;
          im = 0;
        end else begin
          re = quotient(br * ar + bi * ai, den);
          im = quotient(br * ai - bi * ar, den);
        end
      end
    endcase
    a.re = clamp16(re, a.sat);
    a.im = clamp16(im, a.sat);
    return a;
  endfunction

  function automatic logic signed [15:0] rand_part();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return $urandom_range(0, 1) ? 16'sh0100 : 16'shff00;
      4: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_row(logic [1:0] c, logic signed [15:0] ar, ai, br, bi,
                         logic known = 1'b0, logic signed [15:0] re = 0, im = 0,
                         logic sat = 0, logic dz = 0);
    row_t r;
    r.op = '{c, ar, ai, br, bi};
    r.known = known;
    r.ans = '{re, im, sat, dz};
    rows.push_back(r);
  endtask

  // drop valid only when a real pause follows
  task automatic gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_beat(operands_t op);
    in_ch.valid <= 1'b1;
    in_ch.command <= op.command;
    in_ch.a_real <= op.ar;
    in_ch.a_imag <= op.ai;
    in_ch.b_real <= op.br;
    in_ch.b_imag <= op.bi;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // queue the prediction at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      operands_t op;
      op = '{in_ch.command, in_ch.a_real, in_ch.a_imag, in_ch.b_real, in_ch.b_imag};
      answer_q.push_back(predict_answer(op));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      answer_t e;
      if (answer_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result beat");
      end else begin
        e = answer_q.pop_front();
        if (out_ch.res_real !== e.re || out_ch.res_imag !== e.im ||
            out_ch.saturated !== e.sat || out_ch.divide_by_zero !== e.dz) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result: expected %0d %0d sat %b dz %b, got %0d %0d sat %b dz %b",
                     e.re, e.im, e.sat, e.dz, out_ch.res_real, out_ch.res_imag,
                     out_ch.saturated, out_ch.divide_by_zero);
        end
      end
    end
  end

  // sink side: random stalls
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(negedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 60)) @(negedge clk_i);
    end
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    operands_t op;
    answer_t   a;
    in_ch.valid = 1'b0;
    in_ch.command = cau_pkg::CmdAdd;
    in_ch.a_real = 0; in_ch.a_imag = 0; in_ch.b_real = 0; in_ch.b_imag = 0;

    add_row(cau_pkg::CmdAdd, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
            1, 16'sh7fff, 16'sh8000, 1, 0);
    add_row(cau_pkg::CmdAdd, 16'sh0100, 16'sh0200, 16'sh0300, 16'shff00,
            1, 16'sh0400, 16'sh0100, 0, 0);
    add_row(cau_pkg::CmdSub, 16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff,
            1, 16'sh8000, 16'sh7fff, 1, 0);
    add_row(cau_pkg::CmdSub, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000,
            1, 16'sh7fff, 16'sh0000, 1, 0);
    add_row(cau_pkg::CmdMul, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000,
            1, 16'sh0100, 16'sh0000, 0, 0);
    add_row(cau_pkg::CmdMul, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    add_row(cau_pkg::CmdMul, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    add_row(cau_pkg::CmdMul, 16'shffff, 16'sh0000, 16'sh0001, 16'sh0000);
    add_row(cau_pkg::CmdDiv, 16'sh1234, 16'sh8000, 16'sh0000, 16'sh0000,
            1, 16'sh0000, 16'sh0000, 0, 1);
    add_row(cau_pkg::CmdDiv, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000,
            1, 16'sh0100, 16'sh0000, 0, 0);
    add_row(cau_pkg::CmdDiv, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
    add_row(cau_pkg::CmdDiv, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001);
    add_row(cau_pkg::CmdDiv, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    add_row(cau_pkg::CmdDiv, 16'shffff, 16'sh0001, 16'sh0300, 16'shfd00);
    add_row(cau_pkg::CmdMul, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh8000);

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        a = predict_answer(rows[i].op);
        if (a.re !== rows[i].ans.re || a.im !== rows[i].ans.im ||
            a.sat !== rows[i].ans.sat || a.dz !== rows[i].ans.dz) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("table row %0d disagrees with predictor", i);
        end
      end
      send_beat(rows[i].op);
      if ($urandom_range(0, 1)) gap();
    end

    // hold off until the pipeline has drained
    in_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk_i);

    for (int k = 0; k < 1335; k++) begin
      op.command = 2'($urandom_range(0, 3));
      op.ar = rand_part();
      op.ai = rand_part();
      op.br = rand_part();
      op.bi = rand_part();
      if (op.command == cau_pkg::CmdDiv && $urandom_range(0, 15) == 0) begin
        op.br = 0;
        op.bi = 0;
      end
      send_beat(op);
      if ($urandom_range(0, 2) == 0) gap();
    end

    in_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
verif/complex_arithmetic_unit_test.sv
